>>> hw/rtl/anisotropic_variogram_fit_cost_top_defines.svh
// Assertion macros for the variogram fit cost block.
// Used by the port checker; needs clock and reset in the using scope.
`ifndef ANISOTROPIC_VARIOGRAM_FIT_COST_TOP_DEFINES_SVH
`define ANISOTROPIC_VARIOGRAM_FIT_COST_TOP_DEFINES_SVH

// Check while out of reset.
`define AVFC_ASSERT_ON(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("avfc port check failed");

// Check also across reset.
`define AVFC_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("avfc reset check failed");

`endif

>>> hw/rtl/avfc_pkg.sv
// Shared types, constants and divisor tables for the variogram fit cost block.
// No dependencies.
`timescale 1ns / 1ps

package avfc_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int RATIO_W     = 7 + FRAC_BITS;
   localparam int H_W         = RATIO_W + 1;
   localparam int SQ_W        = 2 * RATIO_W + 1;
   localparam int CNT_W       = RATIO_W - FRAC_BITS + 1;
   localparam int DIV_W       = 34 + FRAC_BITS;
   localparam int SHIFT_PAD   = 8;
   localparam int TERM_SH     = 3 * FRAC_BITS - 32 + SHIFT_PAD;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int EXP_TERMS   = 13;
   localparam int SIN_TERMS   = 8;

   localparam logic [30:0]        ONE30     = 31'h4000_0000;
   localparam logic [DIV_W-1:0]   RATIO_CAP = DIV_W'(64) << FRAC_BITS;
   localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(64) << FRAC_BITS;
   localparam logic [63:0]        RCP_NUM   = 64'hFFFF_FFFF;

   localparam logic [31:0] RANGE_MAJOR_RST = 32'd13107200;
   localparam logic [31:0] RANGE_MINOR_RST = 32'd13107200;
   localparam logic [30:0] ANGLE_RST       = 31'd10737418;
   localparam logic [31:0] SILL_ROOT_RST   = 32'd6553600;

   typedef enum logic [1:0] {
      CSR_RANGE_MAJOR,
      CSR_RANGE_MINOR,
      CSR_ANGLE,
      CSR_SILL_ROOT
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] lag_x;
      logic signed [31:0] lag_y;
      logic [31:0]        weight;
      logic [31:0]        empirical_gamma;
      logic               last_lag;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [31:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_X2, ST_SIN_MUL, ST_SIN_DIV, ST_SIN_FIN, ST_COS_MUL, ST_COS_DIV,
      ST_COS_FIN, ST_EXP_MUL, ST_EXP_DIV, ST_EXP_END, ST_UX, ST_UY, ST_RA, ST_RA_W,
      ST_VX, ST_VY, ST_RB, ST_RB_W, ST_SQA, ST_SQB, ST_SQRT, ST_EXPF, ST_EPOW,
      ST_G1, ST_G2, ST_G3, ST_G4, ST_D2, ST_P1, ST_P2, ST_TERM, ST_ACC
   } state_type;

   function automatic logic [8:0] sin_div(input logic [3:0] k);
      logic [8:0] d;
      unique case (k)
         4'd1:    d = 9'd6;
         4'd2:    d = 9'd20;
         4'd3:    d = 9'd42;
         4'd4:    d = 9'd72;
         4'd5:    d = 9'd110;
         4'd6:    d = 9'd156;
         4'd7:    d = 9'd210;
         4'd8:    d = 9'd272;
         default: d = 9'd1;
      endcase
      return d;
   endfunction

   function automatic logic [8:0] cos_div(input logic [3:0] k);
      logic [8:0] d;
      unique case (k)
         4'd2:    d = 9'd12;
         4'd3:    d = 9'd30;
         4'd4:    d = 9'd56;
         4'd5:    d = 9'd90;
         4'd6:    d = 9'd132;
         4'd7:    d = 9'd182;
         4'd8:    d = 9'd240;
         default: d = 9'd1;
      endcase
      return d;
   endfunction

   // floor((2^32 - 1) / d) for each series divisor
   function automatic logic [31:0] sin_rcp(input logic [3:0] k);
      logic [31:0] m;
      unique case (k)
         4'd1:    m = 32'(RCP_NUM / 64'd6);
         4'd2:    m = 32'(RCP_NUM / 64'd20);
         4'd3:    m = 32'(RCP_NUM / 64'd42);
         4'd4:    m = 32'(RCP_NUM / 64'd72);
         4'd5:    m = 32'(RCP_NUM / 64'd110);
         4'd6:    m = 32'(RCP_NUM / 64'd156);
         4'd7:    m = 32'(RCP_NUM / 64'd210);
         4'd8:    m = 32'(RCP_NUM / 64'd272);
         default: m = 32'(RCP_NUM);
      endcase
      return m;
   endfunction

   function automatic logic [31:0] cos_rcp(input logic [3:0] k);
      logic [31:0] m;
      unique case (k)
         4'd2:    m = 32'(RCP_NUM / 64'd12);
         4'd3:    m = 32'(RCP_NUM / 64'd30);
         4'd4:    m = 32'(RCP_NUM / 64'd56);
         4'd5:    m = 32'(RCP_NUM / 64'd90);
         4'd6:    m = 32'(RCP_NUM / 64'd132);
         4'd7:    m = 32'(RCP_NUM / 64'd182);
         4'd8:    m = 32'(RCP_NUM / 64'd240);
         default: m = 32'(RCP_NUM);
      endcase
      return m;
   endfunction

   function automatic logic [31:0] exp_rcp(input logic [3:0] k);
      logic [31:0] m;
      unique case (k)
         4'd2:    m = 32'(RCP_NUM / 64'd2);
         4'd3:    m = 32'(RCP_NUM / 64'd3);
         4'd4:    m = 32'(RCP_NUM / 64'd4);
         4'd5:    m = 32'(RCP_NUM / 64'd5);
         4'd6:    m = 32'(RCP_NUM / 64'd6);
         4'd7:    m = 32'(RCP_NUM / 64'd7);
         4'd8:    m = 32'(RCP_NUM / 64'd8);
         4'd9:    m = 32'(RCP_NUM / 64'd9);
         4'd10:   m = 32'(RCP_NUM / 64'd10);
         4'd11:   m = 32'(RCP_NUM / 64'd11);
         4'd12:   m = 32'(RCP_NUM / 64'd12);
         4'd13:   m = 32'(RCP_NUM / 64'd13);
         default: m = 32'(RCP_NUM);
      endcase
      return m;
   endfunction

endpackage

>>> hw/rtl/avfc_front.sv
// Input side: takes lag words and holds them in a short queue for the engine.
// Depends on avfc_pkg.
`timescale 1ns / 1ps

module avfc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_lag_x,
   input  logic signed [31:0] req_lag_y,
   input  logic [31:0]        req_weight,
   input  logic [31:0]        req_empirical_gamma,
   input  logic               req_last_lag,
   output avfc_pkg::q_head_type q_head,
   input  logic               q_pop
);
   import avfc_pkg::*;

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push, pop;
   item_type          word_in;

   assign req_ready    = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push         = req_valid && req_ready;
   assign pop          = q_pop && (count_ff != '0);
   assign q_head.valid = (count_ff != '0);
   assign q_head.item  = mem_ff[rd_ff];

   always_comb begin
      word_in.lag_x           = req_lag_x;
      word_in.lag_y           = req_lag_y;
      word_in.weight          = req_weight;
      word_in.empirical_gamma = req_empirical_gamma;
      word_in.last_lag        = req_last_lag;
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= word_in;
      end
   end

endmodule

>>> hw/rtl/avfc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on avfc_pkg.
`timescale 1ns / 1ps

module avfc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  avfc_pkg::div_req_type div_req,
   output avfc_pkg::div_rsp_type div_rsp
);
   import avfc_pkg::*;

   localparam int DCNT_W = $clog2(DIV_W + 1);

   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [32:0]       rem_ff, rem_in;
   logic [31:0]       den_ff, den_in;
   logic [32:0]       trial;

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff[31:0], num_ff[DIV_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DIV_W);
         num_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

>>> hw/rtl/avfc_back.sv
// Engine: trig and exp series, ratios, square root, gamma and cost accumulation.
// Depends on avfc_pkg and avfc_div.
`timescale 1ns / 1ps

module avfc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  avfc_pkg::q_head_type q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [63:0]          rsp_weighted_cost,
   output logic                 rsp_cost_saturated
);
   import avfc_pkg::*;

   state_type          state_ff, state_in;
   logic [31:0]        rmaj_ff, rmin_ff, sill_ff;
   logic [30:0]        angle_ff;
   logic               trig_ok_ff, trig_ok_in, e1_ok_ff, e1_ok_in;
   logic               e1_mode_ff, e1_mode_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [30:0]        e1_ff, e1_in, sin_ff, sin_in, r_ff, r_in, f_ff, f_in;
   logic [30:0]        e_ff, e_in, m_ff, m_in;
   logic signed [31:0] cos_ff, cos_in;
   logic [31:0]        x2_ff, x2_in;
   item_type           item_ff, item_in;
   logic signed [63:0] prod_ff, prod_in, u_ff, u_in;
   logic [RATIO_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [SQ_W-1:0]    op_ff, op_in, res_ff, res_in, bit_ff, bit_in;
   logic [H_W-1:0]     h_ff, h_in;
   logic [63:0]        s2_ff, s2_in, t1_ff, t1_in, g_ff, g_in, d2_ff, d2_in;
   logic [63:0]        lop_ff, lop_in, hip_ff, hip_in, term_ff, term_in;
   logic [31:0]        dmag_ff, dmag_in;
   logic               tovf_ff, tovf_in;
   logic [63:0]        acc_ff, acc_in, cost_ff, cost_in;
   logic               ovf_ff, ovf_in, sat_ff, sat_in, rv_ff, rv_in;
   logic [31:0]        cdv_ff, cdv_in, crcp_ff, crcp_in, cq0_ff, cq0_in;
   logic [8:0]         cden_ff, cden_in;
   logic               cph_ff, cph_in;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic [61:0]        sq_ang;
   logic [62:0]        ser_prod;
   logic [61:0]        sin_prod, exp_prod, pow_prod;
   logic [32:0]        ser_q;
   logic signed [33:0] cos_v;
   logic signed [63:0] mul_a, mul_b;
   logic [63:0]        umag;
   logic [DIV_W-1:0]   ratio_num;
   logic [SQ_W:0]      sq_try;
   logic [63:0]        gsum, gclamp, lo_m;
   logic [63:0]        lsum;
   logic               lcarry;
   logic [31:0]        hsum;
   logic [95+SHIFT_PAD:0] pext;
   logic [64:0]        acc_sum;
   logic [63:0]        acc_new;
   logic               ovf_new, out_free;
   logic [63:0]        cprod;
   logic [40:0]        crem;
   logic [31:0]        cq;

   assign rsp_valid          = rv_ff;
   assign rsp_weighted_cost  = cost_ff;
   assign rsp_cost_saturated = sat_ff;
   assign out_free           = !rv_ff || rsp_ready;

   avfc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      sq_ang    = angle_ff * angle_ff;
      ser_prod  = x2_ff * r_ff;
      ser_q     = ser_prod[62:30];
      sin_prod  = angle_ff * r_ff;
      exp_prod  = f_ff * r_ff;
      pow_prod  = e_ff * e1_ff;
      cos_v     = $signed({3'b0, ONE30}) - $signed({2'b0, ser_q[32:1]});
      mul_a     = item_ff.lag_x * cos_ff;
      mul_b     = item_ff.lag_y * $signed({1'b0, sin_ff});
      umag      = u_ff[63] ? 64'(-u_ff) : 64'(u_ff);
      ratio_num = {umag[63:30], FRAC_BITS'(0)};
      sq_try    = {1'b0, res_ff} + {1'b0, bit_ff};
      lo_m      = s2_ff[31:0] * m_ff;
      gsum      = t1_ff + {32'b0, lo_m[63:32]};
      gclamp    = (g_ff > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : g_ff;
      lsum      = lop_ff + {hip_ff[31:0], 32'b0};
      lcarry    = (lsum < lop_ff);
      hsum      = hip_ff[63:32] + 32'(lcarry);
      pext      = {hsum, lsum, SHIFT_PAD'(0)};
      acc_sum   = {1'b0, acc_ff} + {1'b0, term_ff};
      cprod     = cdv_ff * crcp_ff;
      crem      = {9'b0, cdv_ff} - (cq0_ff * cden_ff);
      cq        = (crem >= {32'b0, cden_ff}) ? cq0_ff + 32'd1 : cq0_ff;
      if (tovf_ff || acc_sum[64]) begin
         acc_new = '1;
         ovf_new = 1'b1;
      end else begin
         acc_new = acc_sum[63:0];
         ovf_new = ovf_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      trig_ok_in = trig_ok_ff;
      e1_ok_in   = e1_ok_ff;
      e1_mode_in = e1_mode_ff;
      cnt_in     = cnt_ff;
      e1_in      = e1_ff;
      sin_in     = sin_ff;
      cos_in     = cos_ff;
      r_in       = r_ff;
      f_in       = f_ff;
      e_in       = e_ff;
      m_in       = m_ff;
      x2_in      = x2_ff;
      item_in    = item_ff;
      prod_in    = prod_ff;
      u_in       = u_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      op_in      = op_ff;
      res_in     = res_ff;
      bit_in     = bit_ff;
      h_in       = h_ff;
      s2_in      = s2_ff;
      t1_in      = t1_ff;
      g_in       = g_ff;
      dmag_in    = dmag_ff;
      d2_in      = d2_ff;
      lop_in     = lop_ff;
      hip_in     = hip_ff;
      term_in    = term_ff;
      tovf_in    = tovf_ff;
      acc_in     = acc_ff;
      ovf_in     = ovf_ff;
      cost_in    = cost_ff;
      sat_in     = sat_ff;
      cdv_in     = cdv_ff;
      crcp_in    = crcp_ff;
      cq0_in     = cq0_ff;
      cden_in    = cden_ff;
      cph_in     = cph_ff;
      rv_in      = (rv_ff && !rsp_ready);
      q_pop      = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = 32'd1;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               if (!e1_ok_ff) begin
                  f_in       = ONE30;
                  r_in       = ONE30;
                  cnt_in     = CNT_W'(EXP_TERMS);
                  e1_mode_in = 1'b1;
                  state_in   = ST_EXP_MUL;
               end else if (!trig_ok_ff) begin
                  state_in = ST_X2;
               end else begin
                  item_in  = q_head.item;
                  q_pop    = 1'b1;
                  state_in = ST_UX;
               end
            end
         end
         ST_X2: begin
            x2_in    = sq_ang[61:30];
            r_in     = ONE30;
            cnt_in   = CNT_W'(SIN_TERMS);
            state_in = ST_SIN_MUL;
         end
         ST_SIN_MUL: begin
            cdv_in   = ser_q[31:0];
            cden_in  = sin_div(cnt_ff[3:0]);
            crcp_in  = sin_rcp(cnt_ff[3:0]);
            cph_in   = 1'b0;
            state_in = ST_SIN_DIV;
         end
         ST_SIN_DIV: begin
            if (!cph_ff) begin
               cq0_in = cprod[63:32];
               cph_in = 1'b1;
            end else begin
               r_in   = ONE30 - cq[30:0];
               cnt_in = cnt_ff - 1'b1;
               state_in = (cnt_ff == CNT_W'(1)) ? ST_SIN_FIN : ST_SIN_MUL;
            end
         end
         ST_SIN_FIN: begin
            sin_in   = (sin_prod[61:30] > 32'(ONE30)) ? ONE30 : sin_prod[60:30];
            r_in     = ONE30;
            cnt_in   = CNT_W'(SIN_TERMS);
            state_in = ST_COS_MUL;
         end
         ST_COS_MUL: begin
            cdv_in   = ser_q[31:0];
            cden_in  = cos_div(cnt_ff[3:0]);
            crcp_in  = cos_rcp(cnt_ff[3:0]);
            cph_in   = 1'b0;
            state_in = ST_COS_DIV;
         end
         ST_COS_DIV: begin
            if (!cph_ff) begin
               cq0_in = cprod[63:32];
               cph_in = 1'b1;
            end else begin
               r_in   = ONE30 - cq[30:0];
               cnt_in = cnt_ff - 1'b1;
               state_in = (cnt_ff == CNT_W'(2)) ? ST_COS_FIN : ST_COS_MUL;
            end
         end
         ST_COS_FIN: begin
            if (cos_v > $signed({3'b0, ONE30})) begin
               cos_in = $signed({1'b0, ONE30});
            end else if (cos_v < -$signed({3'b0, ONE30})) begin
               cos_in = -$signed({1'b0, ONE30});
            end else begin
               cos_in = cos_v[31:0];
            end
            trig_ok_in = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_EXP_MUL: begin
            cdv_in   = exp_prod[61:30];
            cden_in  = 9'(cnt_ff);
            crcp_in  = exp_rcp(cnt_ff[3:0]);
            cph_in   = 1'b0;
            state_in = ST_EXP_DIV;
         end
         ST_EXP_DIV: begin
            if (!cph_ff) begin
               cq0_in = cprod[63:32];
               cph_in = 1'b1;
            end else begin
               r_in   = ONE30 - cq[30:0];
               cnt_in = cnt_ff - 1'b1;
               state_in = (cnt_ff == CNT_W'(1)) ? ST_EXP_END : ST_EXP_MUL;
            end
         end
         ST_EXP_END: begin
            if (e1_mode_ff) begin
               e1_in    = r_ff;
               e1_ok_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               e_in     = r_ff;
               cnt_in   = h_ff[H_W-1:FRAC_BITS];
               state_in = ST_EPOW;
            end
         end
         ST_UX: begin
            prod_in  = mul_a;
            state_in = ST_UY;
         end
         ST_UY: begin
            u_in     = prod_ff - mul_b;
            state_in = ST_RA;
         end
         ST_RA: begin
            div_req.start    = 1'b1;
            div_req.dividend = ratio_num;
            div_req.divisor  = (rmaj_ff == '0) ? 32'd1 : rmaj_ff;
            state_in         = ST_RA_W;
         end
         ST_RA_W: begin
            if (div_rsp.done) begin
               a_in = (div_rsp.quotient > RATIO_CAP) ? RATIO_MAX
                                                     : div_rsp.quotient[RATIO_W-1:0];
               state_in = ST_VX;
            end
         end
         ST_VX: begin
            prod_in  = item_ff.lag_x * $signed({1'b0, sin_ff});
            state_in = ST_VY;
         end
         ST_VY: begin
            u_in     = prod_ff + item_ff.lag_y * cos_ff;
            state_in = ST_RB;
         end
         ST_RB: begin
            div_req.start    = 1'b1;
            div_req.dividend = ratio_num;
            div_req.divisor  = (rmin_ff == '0) ? 32'd1 : rmin_ff;
            state_in         = ST_RB_W;
         end
         ST_RB_W: begin
            if (div_rsp.done) begin
               b_in = (div_rsp.quotient > RATIO_CAP) ? RATIO_MAX
                                                     : div_rsp.quotient[RATIO_W-1:0];
               state_in = ST_SQA;
            end
         end
         ST_SQA: begin
            op_in    = SQ_W'(a_ff * a_ff);
            state_in = ST_SQB;
         end
         ST_SQB: begin
            op_in    = op_ff + SQ_W'(b_ff * b_ff);
            res_in   = '0;
            bit_in   = SQ_W'(1) << (2 * RATIO_W);
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (bit_ff == '0) begin
               h_in     = res_ff[H_W-1:0];
               state_in = ST_EXPF;
            end else begin
               if ({1'b0, op_ff} >= sq_try) begin
                  op_in  = op_ff - sq_try[SQ_W-1:0];
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         ST_EXPF: begin
            f_in       = 31'(h_ff[FRAC_BITS-1:0]) << (30 - FRAC_BITS);
            r_in       = ONE30;
            cnt_in     = CNT_W'(EXP_TERMS);
            e1_mode_in = 1'b0;
            state_in   = ST_EXP_MUL;
         end
         ST_EPOW: begin
            if (cnt_ff != '0 && e_ff != '0) begin
               e_in   = pow_prod[60:30];
               cnt_in = cnt_ff - 1'b1;
            end else begin
               state_in = ST_G1;
            end
         end
         ST_G1: begin
            s2_in    = sill_ff * sill_ff;
            m_in     = ONE30 - e_ff;
            state_in = ST_G2;
         end
         ST_G2: begin
            t1_in    = s2_ff[63:32] * m_ff;
            state_in = ST_G3;
         end
         ST_G3: begin
            g_in     = gsum >> (FRAC_BITS - 2);
            state_in = ST_G4;
         end
         ST_G4: begin
            if (g_ff > 64'hFFFF_FFFF) begin
               ovf_in = 1'b1;
            end
            dmag_in = (gclamp[31:0] >= item_ff.empirical_gamma)
                    ? gclamp[31:0] - item_ff.empirical_gamma
                    : item_ff.empirical_gamma - gclamp[31:0];
            state_in = ST_D2;
         end
         ST_D2: begin
            d2_in    = dmag_ff * dmag_ff;
            state_in = ST_P1;
         end
         ST_P1: begin
            lop_in   = item_ff.weight * d2_ff[31:0];
            state_in = ST_P2;
         end
         ST_P2: begin
            hip_in   = item_ff.weight * d2_ff[63:32];
            state_in = ST_TERM;
         end
         ST_TERM: begin
            term_in  = pext[TERM_SH +: 64];
            tovf_in  = ((pext >> (TERM_SH + 64)) != '0);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!item_ff.last_lag) begin
               acc_in   = acc_new;
               ovf_in   = ovf_new;
               state_in = ST_IDLE;
            end else if (out_free) begin
               cost_in  = acc_new;
               sat_in   = ovf_new;
               rv_in    = 1'b1;
               acc_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we && csr_index_type'(csr_index) == CSR_ANGLE) begin
         trig_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         trig_ok_ff <= 1'b0;
         e1_ok_ff   <= 1'b0;
         acc_ff     <= '0;
         ovf_ff     <= 1'b0;
         rv_ff      <= 1'b0;
         rmaj_ff    <= RANGE_MAJOR_RST;
         rmin_ff    <= RANGE_MINOR_RST;
         angle_ff   <= ANGLE_RST;
         sill_ff    <= SILL_ROOT_RST;
      end else begin
         state_ff   <= state_in;
         trig_ok_ff <= trig_ok_in;
         e1_ok_ff   <= e1_ok_in;
         acc_ff     <= acc_in;
         ovf_ff     <= ovf_in;
         rv_ff      <= rv_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_RANGE_MAJOR: rmaj_ff  <= csr_wdata;
               CSR_RANGE_MINOR: rmin_ff  <= csr_wdata;
               CSR_ANGLE:       angle_ff <= csr_wdata[30:0];
               CSR_SILL_ROOT:   sill_ff  <= csr_wdata;
               default:         rmaj_ff  <= rmaj_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      e1_mode_ff <= e1_mode_in;
      cnt_ff     <= cnt_in;
      e1_ff      <= e1_in;
      sin_ff     <= sin_in;
      cos_ff     <= cos_in;
      r_ff       <= r_in;
      f_ff       <= f_in;
      e_ff       <= e_in;
      m_ff       <= m_in;
      x2_ff      <= x2_in;
      item_ff    <= item_in;
      prod_ff    <= prod_in;
      u_ff       <= u_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      op_ff      <= op_in;
      res_ff     <= res_in;
      bit_ff     <= bit_in;
      h_ff       <= h_in;
      s2_ff      <= s2_in;
      t1_ff      <= t1_in;
      g_ff       <= g_in;
      dmag_ff    <= dmag_in;
      d2_ff      <= d2_in;
      lop_ff     <= lop_in;
      hip_ff     <= hip_in;
      term_ff    <= term_in;
      tovf_ff    <= tovf_in;
      cost_ff    <= cost_in;
      sat_ff     <= sat_in;
      cdv_ff     <= cdv_in;
      crcp_ff    <= crcp_in;
      cq0_ff     <= cq0_in;
      cden_ff    <= cden_in;
      cph_ff     <= cph_in;
   end

endmodule

>>> hw/rtl/anisotropic_variogram_fit_cost_top.sv
// One lag word is in the engine at a time; each takes two range divisions, a square root, the
// exp series and the exp power steps, plus any wait for the result word to be taken. Up to
// four words queue. The first word after reset also runs the e^-1, sine and cosine series;
// the first after an angle write runs the sine and cosine series again. Reset is synchronous
// and active high: it clears the queue, the cost sum, the flag and the output, and loads the
// register defaults.
`timescale 1ns / 1ps

module anisotropic_variogram_fit_cost_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_lag_x,
   input  logic signed [31:0] req_lag_y,
   input  logic [31:0]        req_weight,
   input  logic [31:0]        req_empirical_gamma,
   input  logic               req_last_lag,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_weighted_cost,
   output logic               rsp_cost_saturated
);
   import avfc_pkg::*;

   q_head_type q_head;
   logic       q_pop;

   avfc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_lag_x           (req_lag_x),
      .req_lag_y           (req_lag_y),
      .req_weight          (req_weight),
      .req_empirical_gamma (req_empirical_gamma),
      .req_last_lag        (req_last_lag),
      .q_head              (q_head),
      .q_pop               (q_pop)
   );

   avfc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_weighted_cost  (rsp_weighted_cost),
      .rsp_cost_saturated (rsp_cost_saturated)
   );

endmodule

>>> hw/rtl/avfc_check.sv
// Port checker for the variogram fit cost top level, attached by bind.
// Depends on anisotropic_variogram_fit_cost_top_defines.svh.
`timescale 1ns / 1ps
`include "anisotropic_variogram_fit_cost_top_defines.svh"

module avfc_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_weighted_cost,
   input logic        rsp_cost_saturated
);

   `AVFC_ASSERT_ON(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weighted_cost) && $stable(rsp_cost_saturated))
   `AVFC_ASSERT_RST(a_rst_no_rsp, reset |=> !rsp_valid)
   `AVFC_ASSERT_RST(a_rst_ready, reset |=> req_ready)
   `AVFC_ASSERT_RST(a_rst_idle_req, reset && req_valid |=> req_ready)

endmodule

bind anisotropic_variogram_fit_cost_top avfc_check u_avfc_check (.*);
